[src/iaf_pkg.sv]
// ============================================================================
// iaf_pkg
// Shared widths, request and register codes, datapath types and the
// saturation helper for the shift-decay integrate-and-fire neuron.
// ============================================================================
package iaf_pkg;

   localparam int NUM_SYN        = 2;
   localparam int STATE_BITS     = 16;
   localparam int SYN_IDX_BITS   = (NUM_SYN > 1) ? $clog2(NUM_SYN) : 1;
   // Room for the sum of all currents plus the widened leak term.
   localparam int ACC_BITS       = STATE_BITS + 3;
   localparam int SHIFT_BITS     = 4;
   localparam int THRESH_BITS    = 15;
   localparam int COUNT_BITS     = 8;
   localparam int REQ_TYPE_BITS  = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam int WEIGHT_BITS    = 16;

   localparam logic [REQ_TYPE_BITS-1:0] REQ_SPIKE = 2'd0;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_TICK  = 2'd1;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_CLEAR = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MEM_SHIFT   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SYN_SHIFT_A = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SYN_SHIFT_B = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_THRESHOLD   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BIAS_ENABLE = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BIAS_VALUE  = 3'd5;

   typedef logic signed [STATE_BITS-1:0] state_type;
   typedef logic signed [ACC_BITS-1:0]   acc_type;

   localparam acc_type ACC_STATE_MAX = acc_type'((2 ** (STATE_BITS - 1)) - 1);
   localparam acc_type ACC_STATE_MIN = acc_type'(-(2 ** (STATE_BITS - 1)));

   // Operands of the shared decay shifter and adder.
   typedef struct packed {
      state_type               dec_value;
      logic [SHIFT_BITS-1:0]   dec_shift;
      logic                    sub_decay;
      acc_type                 add_a;
      acc_type                 add_b;
   } alu_in_type;

   typedef struct packed {
      state_type decay;
      acc_type   sum;
      state_type sum_sat;
   } alu_out_type;

   function automatic state_type sat_state(input acc_type value);
      state_type result;
      if (value > ACC_STATE_MAX) begin
         result = ACC_STATE_MAX[STATE_BITS-1:0];
      end else if (value < ACC_STATE_MIN) begin
         result = ACC_STATE_MIN[STATE_BITS-1:0];
      end else begin
         result = value[STATE_BITS-1:0];
      end
      return result;
   endfunction

endpackage

[src/iaf_neuron_shift_decay.sv]
// ============================================================================
// iaf_neuron_shift_decay
// Integrate-and-fire neuron with shift-based leak, driven by spike, tick and
// clear requests through a small sequencer around one shared ALU.
// ============================================================================
// Sequence: a spike request passes the spike state and a clear or unknown
// request goes straight to done; a tick walks the decay, sum, leak, bias (only
// with bias enabled), membrane and fire states, emitting at most 255 spikes.
// Throughput: one request at a time; the next is taken once the sequencer
// is back in idle, even while the previous result beat still waits.
// Reset clears neuron state, config registers (threshold to one) and handshake.
module iaf_neuron_shift_decay (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [iaf_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [iaf_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [iaf_pkg::REQ_TYPE_BITS-1:0]      req_type,
   input  logic signed [iaf_pkg::WEIGHT_BITS-1:0] req_weight,
   input  logic                                   req_syn_index,
   input  logic [iaf_pkg::COUNT_BITS-1:0]         req_spikes_before,
   input  logic [iaf_pkg::COUNT_BITS-1:0]         req_spike_limit,
   input  logic                                   req_hibernate_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [iaf_pkg::COUNT_BITS-1:0]         rsp_spikes_out,
   output logic                                   rsp_hibernate_out
);
   import iaf_pkg::*;

   // Sequencer codes. A tick walks decay, sum, leak, bias (if enabled), membrane
   // update and then loops in the fire state, one threshold subtraction per cycle.
   localparam int ST_BITS = 4;
   localparam logic [ST_BITS-1:0] ST_IDLE  = 4'd0;
   localparam logic [ST_BITS-1:0] ST_SPIKE = 4'd1;
   localparam logic [ST_BITS-1:0] ST_DECAY = 4'd2;
   localparam logic [ST_BITS-1:0] ST_SUM   = 4'd3;
   localparam logic [ST_BITS-1:0] ST_LEAK  = 4'd4;
   localparam logic [ST_BITS-1:0] ST_BIAS  = 4'd5;
   localparam logic [ST_BITS-1:0] ST_MEM   = 4'd6;
   localparam logic [ST_BITS-1:0] ST_FIRE  = 4'd7;
   localparam logic [ST_BITS-1:0] ST_DONE  = 4'd8;

   localparam logic [SYN_IDX_BITS-1:0] LAST_SYN = SYN_IDX_BITS'(NUM_SYN - 1);

   // Configuration registers.
   logic [SHIFT_BITS-1:0]  mem_shift_ff,   mem_shift_in;
   logic [SHIFT_BITS-1:0]  syn_shift_a_ff, syn_shift_a_in;
   logic [SHIFT_BITS-1:0]  syn_shift_b_ff, syn_shift_b_in;
   logic [THRESH_BITS-1:0] threshold_ff,   threshold_in;
   logic                   bias_enable_ff, bias_enable_in;
   state_type              bias_value_ff,  bias_value_in;

   // Neuron state.
   state_type membrane_ff, membrane_in;
   state_type syn_ff [NUM_SYN];
   state_type syn_in [NUM_SYN];

   // Sequencer and working registers.
   logic [ST_BITS-1:0]           state_ff, state_in;
   logic [SYN_IDX_BITS-1:0]      idx_ff, idx_in;
   acc_type                      acc_ff, acc_in;
   logic signed [WEIGHT_BITS-1:0] weight_ff, weight_in;
   logic [COUNT_BITS-1:0]        count_ff, count_in;
   logic [COUNT_BITS-1:0]        limit_ff, limit_in;
   logic                         hib_ff, hib_in;

   // Result beat register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0] rsp_spikes_ff, rsp_spikes_in;
   logic                  rsp_hib_ff, rsp_hib_in;

   alu_in_type  alu_in;
   alu_out_type alu_out;
   logic signed [THRESH_BITS:0] thresh_ext;
   logic        shift_sel;
   logic        req_fire;
   logic        rsp_free;

   iaf_alu u_alu (
      .alu_in  (alu_in),
      .alu_out (alu_out)
   );

   assign thresh_ext = {1'b0, threshold_ff};
   assign shift_sel  = (idx_ff == '0);
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   // Operand selection for the shared ALU, one operation per sequencer state.
   always_comb begin
      alu_in.dec_value = membrane_ff;
      alu_in.dec_shift = mem_shift_ff;
      alu_in.sub_decay = 1'b0;
      alu_in.add_a     = '0;
      alu_in.add_b     = '0;
      case (state_ff)
         ST_SPIKE: begin
            alu_in.add_a = acc_type'(syn_ff[idx_ff]);
            alu_in.add_b = acc_type'(weight_ff);
         end
         ST_DECAY: begin
            alu_in.dec_value = syn_ff[idx_ff];
            alu_in.dec_shift = shift_sel ? syn_shift_a_ff : syn_shift_b_ff;
            alu_in.sub_decay = 1'b1;
            alu_in.add_a     = acc_type'(syn_ff[idx_ff]);
         end
         ST_SUM: begin
            alu_in.add_a = acc_ff;
            alu_in.add_b = acc_type'(syn_ff[idx_ff]);
         end
         ST_LEAK: begin
            alu_in.sub_decay = 1'b1;
            alu_in.add_a     = acc_ff;
         end
         ST_BIAS: begin
            alu_in.add_a = acc_ff;
            alu_in.add_b = acc_type'(bias_value_ff);
         end
         ST_MEM: begin
            alu_in.add_a = acc_type'(membrane_ff);
            alu_in.add_b = acc_ff;
         end
         ST_FIRE: begin
            alu_in.add_a = acc_type'(membrane_ff);
            alu_in.add_b = -acc_type'(thresh_ext);
         end
         default: begin
         end
      endcase
   end

   // Next-state logic.
   always_comb begin
      mem_shift_in   = mem_shift_ff;
      syn_shift_a_in = syn_shift_a_ff;
      syn_shift_b_in = syn_shift_b_ff;
      threshold_in   = threshold_ff;
      bias_enable_in = bias_enable_ff;
      bias_value_in  = bias_value_ff;
      membrane_in    = membrane_ff;
      syn_in         = syn_ff;
      state_in       = state_ff;
      idx_in         = idx_ff;
      acc_in         = acc_ff;
      weight_in      = weight_ff;
      count_in       = count_ff;
      limit_in       = limit_ff;
      hib_in         = hib_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_spikes_in  = rsp_spikes_ff;
      rsp_hib_in     = rsp_hib_ff;

      // The user must make configuration writes only while idle; the block does not check.
      if (csr_we) begin
         case (csr_index)
            CSR_MEM_SHIFT:   mem_shift_in   = csr_wdata[SHIFT_BITS-1:0];
            CSR_SYN_SHIFT_A: syn_shift_a_in = csr_wdata[SHIFT_BITS-1:0];
            CSR_SYN_SHIFT_B: syn_shift_b_in = csr_wdata[SHIFT_BITS-1:0];
            CSR_THRESHOLD:   threshold_in   = csr_wdata[THRESH_BITS-1:0];
            CSR_BIAS_ENABLE: bias_enable_in = csr_wdata[0];
            CSR_BIAS_VALUE:  bias_value_in  = state_type'(csr_wdata[STATE_BITS-1:0]);
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               weight_in = req_weight;
               count_in  = req_spikes_before;
               limit_in  = req_spike_limit;
               hib_in    = req_hibernate_in;
               idx_in    = SYN_IDX_BITS'(req_syn_index);
               acc_in    = '0;
               state_in  = ST_DONE;
               case (req_type)
                  REQ_SPIKE: begin
                     // A spike to a synapse that does not exist is dropped.
                     if (int'(req_syn_index) < NUM_SYN) begin
                        state_in = ST_SPIKE;
                     end
                  end
                  REQ_TICK: begin
                     idx_in   = '0;
                     state_in = ST_DECAY;
                  end
                  REQ_CLEAR: begin
                     membrane_in = '0;
                     for (int i = 0; i < NUM_SYN; i++) begin
                        syn_in[i] = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SPIKE: begin
            syn_in[idx_ff] = alu_out.sum_sat;
            state_in       = ST_DONE;
         end
         ST_DECAY: begin
            // The decayed value never leaves the state range.
            syn_in[idx_ff] = alu_out.sum[STATE_BITS-1:0];
            if (alu_out.decay != '0) begin
               hib_in = 1'b0;
            end
            if (idx_ff == LAST_SYN) begin
               idx_in   = '0;
               state_in = ST_SUM;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_SUM: begin
            acc_in = alu_out.sum;
            if (idx_ff == LAST_SYN) begin
               idx_in   = '0;
               state_in = ST_LEAK;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_LEAK: begin
            acc_in   = acc_type'(alu_out.sum_sat);
            state_in = bias_enable_ff ? ST_BIAS : ST_MEM;
         end
         ST_BIAS: begin
            acc_in   = acc_type'(alu_out.sum_sat);
            state_in = ST_MEM;
         end
         ST_MEM: begin
            if (acc_ff != '0) begin
               hib_in = 1'b0;
            end
            membrane_in = alu_out.sum_sat;
            state_in    = ST_FIRE;
         end
         ST_FIRE: begin
            // One spike per cycle while the membrane still reaches the
            // threshold and the count is below the limit.
            if ((count_ff < limit_ff) && !alu_out.sum[ACC_BITS-1]) begin
               membrane_in = alu_out.sum[STATE_BITS-1:0];
               count_in    = count_ff + 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_spikes_in = count_ff;
               rsp_hib_in    = hib_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_shift_ff   <= '0;
         syn_shift_a_ff <= '0;
         syn_shift_b_ff <= '0;
         threshold_ff   <= THRESH_BITS'(1);
         bias_enable_ff <= 1'b0;
         bias_value_ff  <= '0;
         membrane_ff    <= '0;
         for (int i = 0; i < NUM_SYN; i++) begin
            syn_ff[i] <= '0;
         end
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         mem_shift_ff   <= mem_shift_in;
         syn_shift_a_ff <= syn_shift_a_in;
         syn_shift_b_ff <= syn_shift_b_in;
         threshold_ff   <= threshold_in;
         bias_enable_ff <= bias_enable_in;
         bias_value_ff  <= bias_value_in;
         membrane_ff    <= membrane_in;
         syn_ff         <= syn_in;
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Working and payload registers need no reset.
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      acc_ff        <= acc_in;
      weight_ff     <= weight_in;
      count_ff      <= count_in;
      limit_ff      <= limit_in;
      hib_ff        <= hib_in;
      rsp_spikes_ff <= rsp_spikes_in;
      rsp_hib_ff    <= rsp_hib_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_spikes_out    = rsp_spikes_ff;
   assign rsp_hibernate_out = rsp_hib_ff;

endmodule

[src/iaf_alu.sv]
// ============================================================================
// iaf_alu
// Shared arithmetic unit: one arithmetic right shift with a minimum step of
// one unit toward zero, followed by one wide adder with signed saturation.
// ============================================================================
module iaf_alu (
   input  iaf_pkg::alu_in_type  alu_in,
   output iaf_pkg::alu_out_type alu_out
);
   import iaf_pkg::*;

   state_type shifted;
   state_type decay;
   acc_type   operand_b;
   acc_type   sum;

   always_comb begin
      shifted = alu_in.dec_value >>> alu_in.dec_shift;
      // A small positive value still decays by one unit; negative values
      // never shift to zero, so they need no correction.
      if ((shifted == '0) && (alu_in.dec_value > 0)) begin
         decay = state_type'(1);
      end else begin
         decay = shifted;
      end
      operand_b = alu_in.sub_decay ? -acc_type'(decay) : alu_in.add_b;
      sum       = alu_in.add_a + operand_b;
   end

   assign alu_out.decay   = decay;
   assign alu_out.sum     = sum;
   assign alu_out.sum_sat = sat_state(sum);

endmodule

[src/iaf_checker.sv]
// ============================================================================
// iaf_checker
// Port-level checks of the neuron's request and result handshakes.
// ============================================================================
module iaf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   // The block works on one request at a time.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a previous one is still in work");

   // No request is turned around in the cycle after it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("result beat appeared too early");

   // A result beat is never dropped before it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result beat withdrawn before acceptance");

   // Reset leaves no result beat pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat pending after reset");

endmodule

bind iaf_neuron_shift_decay iaf_checker u_iaf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready)
);
